>>> rtl/ips_pkg.sv
// Package for the IPS patch stream parser: phase encoding, result kinds,
// result record type and the header text. Used by all rtl files.
`default_nettype none

package ips_pkg;

	localparam int unsigned AddrW   = 24;
	localparam int unsigned LenW    = 16;
	localparam int unsigned FifoDepth = 4;
	localparam int unsigned FifoPtrW  = $clog2(FifoDepth);

	localparam logic [AddrW-1:0] EofMark = 24'h454F46;
	localparam logic [2:0]       HdrLen  = 3'd5;

	typedef enum logic [2:0] {
		PH_HEADER,
		PH_OFFSET,
		PH_LENGTH,
		PH_LITERAL,
		PH_RCOUNT,
		PH_RFILL,
		PH_STOPPED
	} ips_phase_t;

	typedef enum logic [1:0] {
		KIND_LITERAL = 2'd0,
		KIND_RUN     = 2'd1,
		KIND_ERROR   = 2'd2,
		KIND_END     = 2'd3
	} ips_kind_t;

	typedef struct packed {
		ips_kind_t        kind;
		logic [AddrW-1:0] write_address;
		logic [7:0]       data_byte;
		logic [LenW-1:0]  run_count;
	} ips_res_t;

	typedef struct packed {
		logic full;
		logic empty;
	} ips_fifo_stat_t;

	// Expected header byte at a given position of "PATCH".
	function automatic logic [7:0] hdr_char(input logic [2:0] idx);
		logic [7:0] c;
		case (idx)
			3'd0: c = 8'h50;
			3'd1: c = 8'h41;
			3'd2: c = 8'h54;
			3'd3: c = 8'h43;
			3'd4: c = 8'h48;
			default: c = 8'h00;
		endcase
		return c;
	endfunction

endpackage

`default_nettype wire

>>> rtl/ips_front.sv
// Front end of the IPS parser: header check and record field decoding.
// Depends on ips_pkg; pushes one result record per byte that yields one.
`default_nettype none

module ips_front
	import ips_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_fire,
	input  wire logic [7:0]  in_byte,
	input  wire logic        in_start,
	output logic             res_push,
	output ips_res_t         res
);

	ips_phase_t       phase_q, cur_phase, nxt_phase;
	logic [2:0]       hidx_q, cur_hidx, nxt_hidx;
	logic [AddrW-1:0] acc_q, cur_acc, nxt_acc;
	logic [1:0]       bcnt_q, cur_bcnt, nxt_bcnt;
	logic [AddrW-1:0] offs_q, cur_offs, nxt_offs;
	logic [LenW-1:0]  rem_q, cur_rem, nxt_rem;
	logic [LenW-1:0]  fill_q, cur_fill, nxt_fill;
	logic [AddrW-1:0] shifted;

	// start_patch restarts parsing before this byte is taken
	always_comb begin
		if (in_start) begin
			cur_phase = PH_HEADER;
			cur_hidx  = '0;
			cur_acc   = '0;
			cur_bcnt  = '0;
			cur_offs  = '0;
			cur_rem   = '0;
			cur_fill  = '0;
		end else begin
			cur_phase = phase_q;
			cur_hidx  = hidx_q;
			cur_acc   = acc_q;
			cur_bcnt  = bcnt_q;
			cur_offs  = offs_q;
			cur_rem   = rem_q;
			cur_fill  = fill_q;
		end
		shifted = {cur_acc[AddrW-9:0], in_byte};
	end

	// next state
	always_comb begin
		nxt_phase = cur_phase;
		nxt_hidx  = cur_hidx;
		nxt_acc   = cur_acc;
		nxt_bcnt  = cur_bcnt;
		nxt_offs  = cur_offs;
		nxt_rem   = cur_rem;
		nxt_fill  = cur_fill;
		case (cur_phase)
			PH_HEADER: begin
				if (cur_hidx > 3'd4 || in_byte != hdr_char(cur_hidx)) begin
					nxt_phase = PH_STOPPED;
				end else begin
					nxt_hidx = cur_hidx + 3'd1;
					if (nxt_hidx == HdrLen) begin
						nxt_phase = PH_OFFSET;
						nxt_acc   = '0;
						nxt_bcnt  = '0;
					end
				end
			end
			PH_OFFSET: begin
				nxt_acc  = shifted;
				nxt_bcnt = cur_bcnt + 2'd1;
				if (cur_bcnt == 2'd2) begin
					nxt_bcnt = '0;
					if (shifted == EofMark) begin
						nxt_phase = PH_STOPPED;
					end else begin
						nxt_offs  = shifted;
						nxt_acc   = '0;
						nxt_phase = PH_LENGTH;
					end
				end
			end
			PH_LENGTH: begin
				nxt_acc  = {8'h00, shifted[LenW-1:0]};
				nxt_bcnt = cur_bcnt + 2'd1;
				if (cur_bcnt == 2'd1) begin
					nxt_bcnt = '0;
					nxt_acc  = '0;
					if (shifted[LenW-1:0] == '0) begin
						nxt_phase = PH_RCOUNT;
					end else begin
						nxt_rem   = shifted[LenW-1:0];
						nxt_phase = PH_LITERAL;
					end
				end
			end
			PH_LITERAL: begin
				nxt_offs = cur_offs + AddrW'(1);
				nxt_rem  = cur_rem - LenW'(1);
				if (nxt_rem == '0) begin
					nxt_phase = PH_OFFSET;
					nxt_acc   = '0;
					nxt_bcnt  = '0;
				end
			end
			PH_RCOUNT: begin
				nxt_acc  = {8'h00, shifted[LenW-1:0]};
				nxt_bcnt = cur_bcnt + 2'd1;
				if (cur_bcnt == 2'd1) begin
					nxt_bcnt  = '0;
					nxt_fill  = shifted[LenW-1:0];
					nxt_acc   = '0;
					nxt_phase = PH_RFILL;
				end
			end
			PH_RFILL: begin
				nxt_phase = PH_OFFSET;
				nxt_acc   = '0;
				nxt_bcnt  = '0;
			end
			default: begin
				nxt_phase = cur_phase;
			end
		endcase
	end

	// result outputs
	always_comb begin
		res_push = 1'b0;
		res      = '0;
		case (cur_phase)
			PH_HEADER: begin
				if (cur_hidx > 3'd4 || in_byte != hdr_char(cur_hidx)) begin
					res_push = in_fire;
					res.kind = KIND_ERROR;
				end
			end
			PH_OFFSET: begin
				if (cur_bcnt == 2'd2 && shifted == EofMark) begin
					res_push = in_fire;
					res.kind = KIND_END;
				end
			end
			PH_LITERAL: begin
				res_push          = in_fire;
				res.kind          = KIND_LITERAL;
				res.write_address = cur_offs;
				res.data_byte     = in_byte;
			end
			PH_RFILL: begin
				res_push          = in_fire;
				res.kind          = KIND_RUN;
				res.write_address = cur_offs;
				res.data_byte     = in_byte;
				res.run_count     = cur_fill;
			end
			default: begin
				res_push = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HEADER;
			hidx_q  <= '0;
			acc_q   <= '0;
			bcnt_q  <= '0;
			offs_q  <= '0;
			rem_q   <= '0;
			fill_q  <= '0;
		end else if (in_fire) begin
			phase_q <= nxt_phase;
			hidx_q  <= nxt_hidx;
			acc_q   <= nxt_acc;
			bcnt_q  <= nxt_bcnt;
			offs_q  <= nxt_offs;
			rem_q   <= nxt_rem;
			fill_q  <= nxt_fill;
		end
	end

endmodule

`default_nettype wire

>>> rtl/ips_cmd_fifo.sv
// Short command queue between the parser front end and the output stage.
// Depends on ips_pkg for the result record type and depth.
`default_nettype none

module ips_cmd_fifo
	import ips_pkg::*;
(
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     push,
	input  wire ips_res_t push_data,
	input  wire logic     pop,
	output ips_res_t      head,
	output ips_fifo_stat_t stat
);

	localparam int unsigned CntW = FifoPtrW + 1;

	ips_res_t            mem_q [FifoDepth];
	logic [FifoPtrW-1:0] wr_ptr_q, rd_ptr_q;
	logic [CntW-1:0]     count_q;
	logic                do_push, do_pop;

	assign stat.full  = (count_q == CntW'(FifoDepth));
	assign stat.empty = (count_q == '0);
	assign do_push    = push && !stat.full;
	assign do_pop     = pop && !stat.empty;
	assign head       = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + FifoPtrW'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + FifoPtrW'(1);
			end
			case ({do_push, do_pop})
				2'b10:   count_q <= count_q + CntW'(1);
				2'b01:   count_q <= count_q - CntW'(1);
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

`default_nettype wire

>>> rtl/ips_back.sv
// Output stage: takes commands from the queue into a register and presents
// them as a stream transfer. Depends on ips_pkg.
`default_nettype none

module ips_back
	import ips_pkg::*;
(
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire ips_fifo_stat_t stat,
	input  wire ips_res_t       head,
	output logic                pop,
	input  wire logic           m_axis_tready,
	output logic                m_axis_tvalid,
	output logic [47:0]         m_axis_tdata,
	output logic [1:0]          m_axis_tuser
);

	logic     valid_q;
	ips_res_t out_q;

	// refill when the register is empty or its transfer completes now
	assign pop = !stat.empty && (!valid_q || m_axis_tready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (!valid_q || m_axis_tready) begin
			valid_q <= !stat.empty;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			out_q <= head;
		end
	end

	assign m_axis_tvalid = valid_q;
	assign m_axis_tuser  = out_q.kind;
	assign m_axis_tdata  = {out_q.run_count, out_q.data_byte, out_q.write_address};

endmodule

`default_nettype wire

>>> rtl/ips_patch_stream_parser.sv
// Top level of the IPS patch stream parser: front end, command queue and
// output stage. Depends on ips_pkg, ips_front, ips_cmd_fifo and ips_back.
//
// Channel   Dir  Bits              Contents
// s_axis    in   tdata[7:0]        patch_byte
//                tuser[0]          start_patch
// m_axis    out  tdata[47:0]       write_address[23:0], data_byte[31:24],
//                                  run_count[47:32]
//                tuser[1:0]        kind
//
// One patch byte is taken per cycle while the queue has room; a byte is parsed
// in the cycle of its transfer and any command it yields enters a four-entry queue.
// A result passes through the queue and then the output register before it
// appears on m_axis.
// s_axis_tready drops only while the queue is full, so a stalled consumer
// holds the input back after four pending commands plus the output register.
// Reset clears the phase to header parsing and empties the queue; no
// clearing pass is needed.
`default_nettype none

module ips_patch_stream_parser
	import ips_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [7:0]  s_axis_tdata,   // patch_byte
	input  wire logic        s_axis_tuser,   // start_patch
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic [47:0]      m_axis_tdata,   // write_address, data_byte, run_count
	output logic [1:0]       m_axis_tuser    // kind
);

	logic           in_fire;
	logic           res_push;
	ips_res_t       res;
	ips_res_t       head;
	logic           pop;
	ips_fifo_stat_t stat;

	// hold the input while the queue cannot take a command
	assign s_axis_tready = !stat.full;
	assign in_fire       = s_axis_tvalid && s_axis_tready;

	ips_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_fire  (in_fire),
		.in_byte  (s_axis_tdata),
		.in_start (s_axis_tuser),
		.res_push (res_push),
		.res      (res)
	);

	ips_cmd_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (res_push),
		.push_data (res),
		.pop       (pop),
		.head      (head),
		.stat      (stat)
	);

	ips_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.stat          (stat),
		.head          (head),
		.pop           (pop),
		.m_axis_tready (m_axis_tready),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

endmodule

`default_nettype wire
